// ===== src/bce_pkg.sv =====
package bce_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORDS          = 10;

    localparam logic [3:0] W_T0 = 4'd0;
    localparam logic [3:0] W_DT = 4'd1;
    localparam logic [3:0] W_A0 = 4'd2;
    localparam logic [3:0] W_B0 = 4'd6;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic signed [31:0] T_ONE = 32'sd65536;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         entry_index;
        logic [3:0]         word_select;
        logic signed [31:0] word_value;
        logic signed [31:0] t_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic [16:0]        curve_frac;
        logic               done_res;
    } out_item_t;

    // Command and handshake between sequencer and Horner unit.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } horner_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== src/bezier_curve_evaluator_top.sv =====
// Piecewise cubic Bezier evaluator. A load item writes one word of the
// segment table, and ready stays high after it. An evaluate item runs a
// binary search over the segment start times (one table read per probe),
// then FRAC_BITS bisection steps that each evaluate x(f) on the single
// shared multiplier, then one evaluation of y(f). Each polynomial evaluation
// runs a start step, a coefficient fetch, three multiply and add pairs and a
// done step. With 64 points in use the search makes six probes. An item at
// either end of the curve skips the search and the bisection, and one that
// lands on a segment of non-positive width skips the bisection. The shared
// multiplier and the single table read port make these steps run one after
// another. Ready is low while an item is at work or while its result waits.
// Table words read before being written give undefined results.
module bezier_curve_evaluator_top
    import bce_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int IW    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int DEPTH = MAX_POINTS * WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(FRAC_BITS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SRCH  = 10'b0000000010,
        S_SCMP  = 10'b0000000100,
        S_DTRD  = 10'b0000001000,
        S_DTCHK = 10'b0000010000,
        S_XEV   = 10'b0000100000,
        S_XWAIT = 10'b0001000000,
        S_YEV   = 10'b0010000000,
        S_YWAIT = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] mem [DEPTH];
    logic [AW-1:0] raddr;
    logic signed [31:0] rdata_reg;

    logic [6:0] pts_reg;
    logic [IW:0] n_eff;
    logic [IW:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic signed [31:0] t_reg, t_next;
    logic [FRAC_BITS:0] f0_reg, f0_next, f1_reg, f1_next, fm;
    logic [SW-1:0] step_reg, step_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic h_start;
    logic [1:0] h_sel;
    horner_ctl_t h_ctl;
    logic signed [31:0] h_res;
    logic [FRAC_BITS:0] h_f;
    logic signed [31:0] t_clamp;
    logic [16:0] frac16;
    logic [3:0] base_w;
    logic [3:0] word_sel;
    logic [IW-1:0] rentry;

    // Clamp the point count to the supported range.
    always_comb
    begin
        if (pts_reg < 7'd2)
            n_eff = (IW+1)'(2);
        else if (32'(pts_reg) > MAX_POINTS)
            n_eff = (IW+1)'(MAX_POINTS);
        else
            n_eff = (IW+1)'(pts_reg);
    end

    assign mid = (lo_reg + hi_reg) >> 1;
    assign fm  = (f0_reg + f1_reg) >> 1;
    assign h_f = (state_reg == S_YEV || state_reg == S_YWAIT) ? f0_reg : fm;

    always_comb
    begin
        if (in_data.t_in < 32'sd0)
            t_clamp = 32'sd0;
        else if (in_data.t_in > T_ONE)
            t_clamp = T_ONE;
        else
            t_clamp = in_data.t_in;
    end

    generate
        if (FRAC_BITS >= 16)
        begin : g_fr_hi
            assign frac16 = 17'(f0_reg >> (FRAC_BITS - 16));
        end
        else
        begin : g_fr_lo
            assign frac16 = 17'({1'b0, f0_reg} << (16 - FRAC_BITS));
        end
    endgenerate

    // Read address selection.
    always_comb
    begin
        base_w   = (state_reg == S_YEV || state_reg == S_YWAIT) ? W_B0 : W_A0;
        rentry   = lo_reg[IW-1:0];
        word_sel = base_w + {2'b00, h_sel};
        case (state_reg)
            S_SRCH:
            begin
                rentry   = mid[IW-1:0];
                word_sel = W_T0;
            end
            S_DTRD:  word_sel = W_DT;
            S_DTCHK: word_sel = W_B0;
            default: ;
        endcase
        raddr = AW'(32'(rentry) * WORDS + 32'(word_sel));
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && in_data.cmd == CMD_LOAD &&
            in_data.word_select < 4'(WORDS) && 32'(in_data.entry_index) < MAX_POINTS)
            mem[AW'(32'(in_data.entry_index) * WORDS + 32'(in_data.word_select))]
                <= in_data.word_value;
        rdata_reg <= mem[raddr];
    end

    bce_horner #(.FRAC_BITS(FRAC_BITS)) u_horner (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (h_start),
        .f        (h_f),
        .coef     (rdata_reg),
        .coef_sel (h_sel),
        .ctl      (h_ctl),
        .result   (h_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        t_next         = t_reg;
        f0_next        = f0_reg;
        f1_next        = f1_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        h_start        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_data.cmd == CMD_EVAL)
                begin
                    t_next  = t_clamp;
                    lo_next = '0;
                    hi_next = n_eff;
                    out_next.done_res   = (t_clamp == T_ONE);
                    out_next.curve_frac = (t_clamp == T_ONE) ? 17'd65536 : 17'd0;
                    if (t_clamp == 32'sd0)
                        state_next = S_DTCHK;
                    else if (t_clamp == T_ONE)
                    begin
                        lo_next    = n_eff - (IW+1)'(1);
                        state_next = S_DTCHK;
                    end
                    else
                        state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (hi_reg - lo_reg > (IW+1)'(1))
                    state_next = S_SCMP;
                else
                    state_next = S_DTRD;
            end
            S_SCMP:
            begin
                if (rdata_reg > t_reg)
                    hi_next = mid;
                else
                    lo_next = mid;
                state_next = S_SRCH;
            end
            S_DTRD:
            begin
                // b0 is read next as the fallback for a non-positive width.
                state_next = S_DTCHK;
            end
            S_DTCHK:
            begin
                // Here rdata holds dt for searched items, b0 is being read.
                if (out_reg.done_res || t_reg == 32'sd0 || rdata_reg <= 32'sd0)
                    state_next = S_OUT;
                else
                begin
                    f0_next    = '0;
                    f1_next    = (FRAC_BITS+1)'(1) << FRAC_BITS;
                    step_next  = '0;
                    state_next = S_XEV;
                end
            end
            S_XEV:
            begin
                h_start    = 1'b1;
                state_next = S_XWAIT;
            end
            S_XWAIT:
            begin
                if (h_ctl.done)
                begin
                    if (h_res > t_reg)
                        f1_next = fm;
                    else
                        f0_next = fm;
                    step_next = step_reg + SW'(1);
                    if (32'(step_reg) == FRAC_BITS - 1)
                        state_next = S_YEV;
                    else
                        state_next = S_XEV;
                end
            end
            S_YEV:
            begin
                h_start    = 1'b1;
                state_next = S_YWAIT;
            end
            S_YWAIT:
            begin
                if (h_ctl.done)
                begin
                    out_next.curve_value = h_res;
                    out_next.curve_frac  = frac16;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            S_OUT:
            begin
                out_next.curve_value = rdata_reg;
                out_valid_next       = 1'b1;
                state_next           = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    // S_OUT directly follows S_DTCHK, which holds the b0 address, so rdata
    // in S_OUT is b0.
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pts_reg       <= 7'd2;
        end
        else
        begin
            if (!(in_valid && in_ready))
                state_reg <= (state_reg == S_IDLE) ? S_IDLE : state_next;
            else
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                pts_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        t_reg    <= t_next;
        f0_reg   <= f0_next;
        f1_reg   <= f1_next;
        step_reg <= step_next;
        if (state_reg != S_IDLE || (in_valid && in_ready))
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== src/bce_horner.sv =====
// Shared Horner unit, started only when idle: one multiplier, registered
// product, then shift, add, saturate. The caller fetches coefficients from memory.
module bce_horner
    import bce_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [FRAC_BITS:0]     f,
    input  logic signed [31:0]     coef,
    output logic [1:0]             coef_sel,
    output horner_ctl_t            ctl,
    output logic signed [31:0]     result
);

    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_LOAD = 4'b0010,
        H_MUL  = 4'b0100,
        H_ADD  = 4'b1000
    } h_state_t;

    h_state_t                  state_reg, state_next;
    logic [1:0]                idx_reg, idx_next;
    logic signed [31:0]        acc_reg, acc_next;
    logic signed [FRAC_BITS+33:0] prod_reg, prod_next;
    logic signed [FRAC_BITS+33:0] shifted;
    logic                      done_reg, done_next;

    assign shifted = prod_reg >>> FRAC_BITS;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    idx_next   = 2'd3;
                    state_next = H_LOAD;
                end
            end
            H_LOAD:
            begin
                // Coefficient data arrives in the cycle after its address.
                acc_next   = coef;
                idx_next   = 2'd2;
                state_next = H_MUL;
            end
            H_MUL:
            begin
                prod_next  = acc_reg * $signed({1'b0, f});
                state_next = H_ADD;
            end
            H_ADD:
            begin
                acc_next = sat32(34'(shifted) + 34'(coef));
                if (idx_reg == 2'd0)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg - 2'd1;
                    state_next = H_MUL;
                end
            end
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
            idx_reg   <= 2'd3;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    // Address for the next read: in IDLE/LOAD ask for c3, otherwise current index.
    assign coef_sel  = (state_reg == H_IDLE) ? 2'd3 : idx_reg;
    assign ctl.start = start;
    assign ctl.busy  = (state_reg != H_IDLE);
    assign ctl.done  = done_reg;
    assign result    = acc_reg;

endmodule
